// File: hdl/tswd_pkg.sv
// ---------------------------------------------------------------------------
// tswd_pkg
// Shared types and constants for the task supervised watchdog.
// ---------------------------------------------------------------------------
package tswd_pkg;

  localparam int unsigned   WORD_W         = 32;
  localparam int unsigned   ACTION_W       = 3;
  localparam int unsigned   TASK_W         = 5;
  localparam int unsigned   NUM_TASKS      = 32;
  localparam int unsigned   SLOW_CLOCK_HZ  = 32768;
  localparam int unsigned   DEFAULT_SECS   = 10;
  localparam logic [31:0]   TIMEOUT_RESET  = 32'(SLOW_CLOCK_HZ * DEFAULT_SECS);
  localparam logic [31:0]   MIN_TICKS      = 32'd15;
  localparam logic [31:0]   RELOAD_MAGIC   = 32'h6E52_4635;

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_REGISTER = 3'd2;
  localparam logic [2:0] ACT_UNREG    = 3'd3;
  localparam logic [2:0] ACT_FEED     = 3'd4;
  localparam logic [2:0] ACT_RELOAD   = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TASK_W-1:0]   task_id;
    logic [WORD_W-1:0]   reload_word;
  } item_t;

  typedef struct packed {
    logic              timeout;
    logic              kicked;
    logic              is_running;
    logic [WORD_W-1:0] registered_now;
    logic [WORD_W-1:0] fed_now;
    logic [WORD_W-1:0] remaining;
  } result_t;

endpackage

// File: hdl/task_supervised_watchdog.sv
// ---------------------------------------------------------------------------
// task_supervised_watchdog
// Watchdog timer kept alive by up to 32 supervised tasks.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | in        | in_valid / in_stall | action, task_id, reload_word
//  out_    | out       | out_valid/out_stall | timeout, kicked, is_running, masks, remaining
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data (timeout_ticks)
//
// One event per clock sustained while out_stall is low. The input transfer loads
// the input register; the state update then loads the result register, from
// which the result transfers.
// The state update is a single pass: mask logic plus one 32-bit decrement.
// A stalled result holds while the input register still takes one event.
// Synchronous active-low reset clears state; timeout_ticks resets to 327680.
// ---------------------------------------------------------------------------
module task_supervised_watchdog
  import tswd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [TASK_W-1:0]   in_task_id,
  input  logic [WORD_W-1:0]   in_reload_word,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_timeout,
  output logic                out_kicked,
  output logic                out_is_running,
  output logic [WORD_W-1:0]   out_registered_now,
  output logic [WORD_W-1:0]   out_fed_now,
  output logic [WORD_W-1:0]   out_remaining,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WORD_W-1:0]   cfg_data
);

  item_t   in_item, item;
  logic    item_valid, advance;
  result_t result, result_r;
  logic    out_valid_r, out_valid_nxt;

  assign in_item = '{action: in_action, task_id: in_task_id, reload_word: in_reload_word};

  // event moves on when the result register is empty or being drained
  assign advance       = item_valid & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = advance | (out_valid_r & out_stall);
  assign cfg_ready     = 1'b1;

  tswd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tswd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .advance  (advance),
    .item     (item),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_timeout        = result_r.timeout;
  assign out_kicked         = result_r.kicked;
  assign out_is_running     = result_r.is_running;
  assign out_registered_now = result_r.registered_now;
  assign out_fed_now        = result_r.fed_now;
  assign out_remaining      = result_r.remaining;

endmodule

// File: hdl/tswd_in_stage.sv
// ---------------------------------------------------------------------------
// tswd_in_stage
// Input register: holds one event until the core consumes it.
// ---------------------------------------------------------------------------
module tswd_in_stage
  import tswd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // stage frees up whenever its content moves on this cycle
  assign in_stall  = valid_r & ~advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: hdl/tswd_core.sv
// ---------------------------------------------------------------------------
// tswd_core
// Watchdog state (masks, down counter, running flag, reload register) and
// the single-pass update for one event.
// ---------------------------------------------------------------------------
module tswd_core
  import tswd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              advance,
  input  item_t             item,
  output result_t           result
);

  logic [WORD_W-1:0] timeout_ticks_r;
  logic [WORD_W-1:0] reg_mask_r, reg_mask_nxt;
  logic [WORD_W-1:0] fed_mask_r, fed_mask_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic              running_r, running_nxt;

  logic [WORD_W-1:0] reload_val;
  logic [WORD_W-1:0] task_bit;
  logic [WORD_W-1:0] reg_upd, fed_upd;
  logic              task_ok;
  logic              all_fed;
  logic              timeout, kicked;

  assign reload_val = (timeout_ticks_r < MIN_TICKS) ? MIN_TICKS : timeout_ticks_r;
  assign task_ok    = 7'(item.task_id) < 7'(NUM_TASKS);
  assign task_bit   = task_ok ? (WORD_W'(1) << item.task_id) : '0;

  // masks as they stand after an unregister or a feed, before the all-fed check
  always_comb begin
    reg_upd = reg_mask_r;
    fed_upd = fed_mask_r;
    if (item.action == ACT_UNREG) begin
      reg_upd = reg_mask_r & ~task_bit;
      fed_upd = fed_mask_r & ~task_bit;
    end else begin
      fed_upd = fed_mask_r | task_bit;
    end
  end

  assign all_fed = (fed_upd & reg_upd) == reg_upd;

  always_comb begin
    reg_mask_nxt = reg_mask_r;
    fed_mask_nxt = fed_mask_r;
    count_nxt    = count_r;
    running_nxt  = running_r;
    timeout      = 1'b0;
    kicked       = 1'b0;
    unique case (item.action)
      ACT_TICK: begin
        if (running_r) begin
          if (count_r <= WORD_W'(1)) begin
            reg_mask_nxt = '0;
            fed_mask_nxt = '0;
            count_nxt    = '0;
            running_nxt  = 1'b0;
            timeout      = 1'b1;
          end else begin
            count_nxt = count_r - WORD_W'(1);
          end
        end
      end
      ACT_START: begin
        if (!running_r) begin
          count_nxt   = reload_val;
          running_nxt = 1'b1;
        end
      end
      ACT_REGISTER: begin
        reg_mask_nxt = reg_mask_r | task_bit;
      end
      ACT_UNREG, ACT_FEED: begin
        if (task_ok) begin
          reg_mask_nxt = reg_upd;
          fed_mask_nxt = all_fed ? '0 : fed_upd;
          if (all_fed && running_r) begin
            count_nxt = reload_val;
            kicked    = 1'b1;
          end
        end
      end
      ACT_RELOAD: begin
        if (running_r && item.reload_word == RELOAD_MAGIC) begin
          count_nxt = reload_val;
          kicked    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_RESET;
      reg_mask_r      <= '0;
      fed_mask_r      <= '0;
      count_r         <= '0;
      running_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks_r <= cfg_data;
      end
      if (advance) begin
        reg_mask_r <= reg_mask_nxt;
        fed_mask_r <= fed_mask_nxt;
        count_r    <= count_nxt;
        running_r  <= running_nxt;
      end
    end
  end

  assign result = '{timeout:        timeout,
                    kicked:         kicked,
                    is_running:     running_nxt,
                    registered_now: reg_mask_nxt,
                    fed_now:        fed_mask_nxt,
                    remaining:      count_nxt};

endmodule

// File: hdl/tswd_checker.sv
// ---------------------------------------------------------------------------
// tswd_checker
// Port-level checks for the task supervised watchdog.
// ---------------------------------------------------------------------------
module tswd_checker
  import tswd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_timeout,
  input logic              out_kicked,
  input logic              out_is_running,
  input logic [WORD_W-1:0] out_registered_now,
  input logic [WORD_W-1:0] out_fed_now,
  input logic [WORD_W-1:0] out_remaining
);

  // a timeout clears the masks, the counter and the running flag
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timeout |-> !out_is_running && out_registered_now == '0
                                 && out_fed_now == '0 && out_remaining == '0)
    else $error("timeout result does not show cleared state");

  // counter is nonzero exactly while running
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_running == (out_remaining != '0))
    else $error("running flag and counter disagree");

  a_kick_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kicked |-> out_is_running && !out_timeout)
    else $error("kick reported while stopped or timing out");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_remaining)
                               && $stable(out_fed_now))
    else $error("stalled result changed");

endmodule

bind task_supervised_watchdog tswd_checker u_tswd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_timeout        (out_timeout),
  .out_kicked         (out_kicked),
  .out_is_running     (out_is_running),
  .out_registered_now (out_registered_now),
  .out_fed_now        (out_fed_now),
  .out_remaining      (out_remaining)
);
